// File: rtl/sola_pkg.sv
package sola_pkg;

    localparam int CAPACITY_NODES_DEF = 64;
    localparam int DATA_WIDTH_DEF     = 32;
    localparam int CMD_W              = 2;
    localparam int ELEM_W             = 32;

    localparam logic [CMD_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [CMD_W-1:0] OP_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] OP_REMOVE = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic rd_head;
        logic rd_next;
        logic rd_free;
        logic add_w1;
        logic add_w2;
        logic rm_w1;
        logic rm_w2;
        logic set_ok;
        logic load_out;
    } sola_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             head_valid;
        logic             free_valid;
        logic             match;
        logic             walk_more;
        logic             out_free;
    } sola_stat_t;

endpackage

// File: rtl/sola_ctrl.sv
module sola_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sola_pkg::sola_stat_t  stat,
    output sola_pkg::sola_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_ADD_W1,
        S_ADD_W2,
        S_RM_W1,
        S_RM_W2,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   hit;
    logic   miss;

    assign in_ready = (state_reg == S_IDLE);

    assign hit  = (state_reg == S_WALK) && stat.match;
    assign miss = ((state_reg == S_START) && !stat.head_valid) ||
                  ((state_reg == S_WALK) && !stat.match && !stat.walk_more);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                if (stat.op == sola_pkg::OP_SEARCH || stat.op == sola_pkg::OP_ADD ||
                    stat.op == sola_pkg::OP_REMOVE)
                begin
                    if (stat.head_valid)
                    begin
                        cmd.rd_head = 1'b1;
                        state_next  = S_WALK;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WALK:
            begin
                if (!stat.match && stat.walk_more)
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_ADD_W1:
            begin
                cmd.add_w1 = 1'b1;
                state_next = S_ADD_W2;
            end
            S_ADD_W2:
            begin
                cmd.add_w2 = 1'b1;
                cmd.set_ok = 1'b1;
                state_next = S_DONE;
            end
            S_RM_W1:
            begin
                cmd.rm_w1  = 1'b1;
                state_next = S_RM_W2;
            end
            S_RM_W2:
            begin
                cmd.rm_w2  = 1'b1;
                cmd.set_ok = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register can take the word
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (hit)
        begin
            if (stat.op == sola_pkg::OP_REMOVE)
            begin
                state_next = S_RM_W1;
            end
            else
            begin
                cmd.set_ok = (stat.op == sola_pkg::OP_SEARCH);
                state_next = S_DONE;
            end
        end

        if (miss)
        begin
            if (stat.op == sola_pkg::OP_ADD && stat.free_valid)
            begin
                cmd.rd_free = 1'b1;
                state_next  = S_ADD_W1;
            end
            else
            begin
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/sola_dp.sv
module sola_dp
#(
    parameter int CAPACITY_NODES = sola_pkg::CAPACITY_NODES_DEF,
    parameter int DATA_WIDTH     = sola_pkg::DATA_WIDTH_DEF,
    localparam int CNT_W         = $clog2(CAPACITY_NODES + 1)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sola_pkg::sola_cmd_t           cmd,
    output sola_pkg::sola_stat_t          stat,
    input  logic [sola_pkg::CMD_W-1:0]    in_cmd,
    input  logic [sola_pkg::ELEM_W-1:0]   in_elem,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_success,
    output logic [CNT_W-1:0]              out_count,
    output logic                          out_empty
);

    localparam int IW = $clog2(CAPACITY_NODES);
    localparam int LW = IW + 1;
    localparam int SW = CNT_W;
    localparam logic [LW-1:0] NIL   = '1;
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY_NODES);
    localparam logic [SW-1:0] CAP_S = SW'(CAPACITY_NODES);

    logic [DATA_WIDTH-1:0] val_mem  [CAPACITY_NODES];
    logic [LW-1:0]         next_mem [CAPACITY_NODES];
    logic [LW-1:0]         prev_mem [CAPACITY_NODES];

    logic [sola_pkg::CMD_W-1:0] op_reg;
    logic [DATA_WIDTH-1:0]      v_reg;
    logic [LW-1:0]              head_reg,  head_next;
    logic [LW-1:0]              tail_reg,  tail_next;
    logic [LW-1:0]              free_reg,  free_next;
    logic [LW-1:0]              hw_reg,    hw_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [LW-1:0]              cur_reg,   cur_next;
    logic [SW-1:0]              steps_reg, steps_next;
    logic                       ok_reg,    ok_next;
    logic                       out_valid_reg;
    logic                       out_success_reg;
    logic [CNT_W-1:0]           out_count_reg;
    logic                       out_empty_reg;

    logic [DATA_WIDTH-1:0] rd_val;
    logic [LW-1:0]         rd_next;
    logic [LW-1:0]         rd_prev;

    logic                  head_ok, tail_ok, free_ok, p_ok, q_ok, virgin;
    logic [LW-1:0]         cur_inc, virgin_next;
    logic [SW-1:0]         steps_inc;
    logic                  rd_en;
    logic [LW-1:0]         rd_addr;

    logic                  next_we, prev_we, val_we;
    logic [LW-1:0]         next_wa, prev_wa;
    logic [LW-1:0]         next_wd, prev_wd;

    assign head_ok   = head_reg < CAP_L;
    assign tail_ok   = tail_reg < CAP_L;
    assign free_ok   = free_reg < CAP_L;
    assign p_ok      = rd_prev < CAP_L;
    assign q_ok      = rd_next < CAP_L;
    // nodes at or above the high-water mark were never allocated: their link is i plus one, or NIL for the last node
    assign virgin      = cur_reg >= hw_reg;
    assign cur_inc     = cur_reg + LW'(1);
    assign virgin_next = (cur_inc < CAP_L) ? cur_inc : NIL;
    assign steps_inc   = steps_reg + SW'(1);

    assign stat.op         = op_reg;
    assign stat.head_valid = head_ok;
    assign stat.free_valid = free_ok;
    assign stat.match      = (rd_val == v_reg);
    assign stat.walk_more  = q_ok && (steps_inc < CAP_S);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign rd_en   = cmd.rd_head || cmd.rd_next || cmd.rd_free;
    assign rd_addr = cmd.rd_head ? head_reg : (cmd.rd_next ? rd_next : free_reg);

    always_comb
    begin
        next_we = 1'b0;
        next_wa = cur_reg;
        next_wd = NIL;
        prev_we = 1'b0;
        prev_wa = cur_reg;
        prev_wd = NIL;
        val_we  = cmd.add_w1;
        if (cmd.add_w1)
        begin
            next_we = head_ok && tail_ok;
            next_wa = tail_reg;
            next_wd = cur_reg;
            prev_we = 1'b1;
            prev_wd = tail_reg;
        end
        else if (cmd.add_w2)
        begin
            next_we = 1'b1;
        end
        else if (cmd.rm_w1)
        begin
            next_we = p_ok;
            next_wa = rd_prev;
            next_wd = rd_next;
            prev_we = q_ok;
            prev_wa = rd_next;
            prev_wd = rd_prev;
        end
        else if (cmd.rm_w2)
        begin
            next_we = 1'b1;
            next_wd = free_reg;
            prev_we = 1'b1;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        free_next  = free_reg;
        hw_next    = hw_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        steps_next = steps_reg;
        ok_next    = ok_reg;

        if (cmd.load_in)
        begin
            ok_next = 1'b0;
        end
        if (cmd.set_ok)
        begin
            ok_next = 1'b1;
        end

        if (cmd.rd_head)
        begin
            cur_next   = head_reg;
            steps_next = '0;
        end
        else if (cmd.rd_next)
        begin
            cur_next   = rd_next;
            steps_next = steps_inc;
        end
        else if (cmd.rd_free)
        begin
            cur_next = free_reg;
        end

        if (cmd.add_w1)
        begin
            free_next = virgin ? virgin_next : rd_next;
            if (virgin)
            begin
                hw_next = cur_inc;
            end
        end
        if (cmd.add_w2)
        begin
            tail_next  = cur_reg;
            count_next = count_reg + CNT_W'(1);
            if (!head_ok)
            begin
                head_next = cur_reg;
            end
        end
        if (cmd.rm_w1)
        begin
            if (!p_ok)
            begin
                head_next = rd_next;
            end
            if (!q_ok)
            begin
                tail_next = rd_prev;
            end
        end
        if (cmd.rm_w2)
        begin
            free_next = cur_reg;
            if (count_reg != '0)
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[cur_reg[IW-1:0]] <= v_reg;
        end
        if (next_we)
        begin
            next_mem[next_wa[IW-1:0]] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa[IW-1:0]] <= prev_wd;
        end
        if (rd_en)
        begin
            rd_val  <= val_mem[rd_addr[IW-1:0]];
            rd_next <= next_mem[rd_addr[IW-1:0]];
            rd_prev <= prev_mem[rd_addr[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        steps_reg <= steps_next;
        ok_reg    <= ok_next;
        if (cmd.load_in)
        begin
            op_reg <= in_cmd;
            v_reg  <= DATA_WIDTH'(signed'(in_elem));
        end
        if (cmd.load_out)
        begin
            out_success_reg <= ok_reg;
            out_count_reg   <= count_reg;
            out_empty_reg   <= (count_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= NIL;
            tail_reg      <= NIL;
            free_reg      <= '0;
            hw_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            free_reg  <= free_next;
            hw_reg    <= hw_next;
            count_reg <= count_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_success = out_success_reg;
    assign out_count   = out_count_reg;
    assign out_empty   = out_empty_reg;

endmodule

// File: rtl/set_on_linked_array.sv
// Operation: a word is taken, the list is walked one node per cycle from the head,
// then add and remove take up to two link-update steps (W1, W2) before the result word
// is loaded; k nodes are visited, at most CAPACITY_NODES. A new word is accepted only
// once the previous result has been loaded into the output register.
// Reset (rst_n, async, active low) empties the set at once; never-used nodes are
// tracked by a high-water mark, so no clearing pass is needed.
module set_on_linked_array
#(
    parameter int CAPACITY_NODES = sola_pkg::CAPACITY_NODES_DEF,
    parameter int DATA_WIDTH     = sola_pkg::DATA_WIDTH_DEF,
    localparam int CNT_W         = $clog2(CAPACITY_NODES + 1),
    localparam int IN_W          = ((sola_pkg::CMD_W + sola_pkg::ELEM_W + 7) / 8) * 8,
    localparam int OUT_W         = ((CNT_W + 2 + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // cmd, element
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // success, count, is_empty
);

    sola_pkg::sola_cmd_t  cmd;
    sola_pkg::sola_stat_t stat;
    logic                 success;
    logic [CNT_W-1:0]     count;
    logic                 is_empty;

    sola_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sola_dp
    #(
        .CAPACITY_NODES (CAPACITY_NODES),
        .DATA_WIDTH     (DATA_WIDTH)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_cmd      (s_axis_tdata[sola_pkg::CMD_W-1:0]),
        .in_elem     (s_axis_tdata[sola_pkg::CMD_W +: sola_pkg::ELEM_W]),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_success (success),
        .out_count   (count),
        .out_empty   (is_empty)
    );

    assign m_axis_tdata = OUT_W'({is_empty, count, success});

endmodule

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W      = 40;
    localparam int OUT_W     = 16;
    localparam int CAP       = 64;
    localparam int WDOG_MAX  = 4000;
    localparam int HOLD_LEN  = 600;
    localparam int N_PHASES  = 8;
    localparam int PHASE_LEN = 216;

    // cmd 3 is not decoded by the block
    localparam logic [sola_pkg::CMD_W-1:0] OP_NONE = 2'd3;
    localparam logic [6:0]                 NIL     = 7'h7F;

    typedef struct {
        logic       success;
        logic [6:0] count;
        logic       is_empty;
    } set_resp_t;

    typedef struct {
        bit        typed;
        set_resp_t resp;
    } pend_t;

    typedef struct {
        logic [sola_pkg::CMD_W-1:0] op;
        logic [31:0]                elem;
        bit                         typed;
        logic                       ok;
        logic [6:0]                 cnt;
        logic                       emp;
    } dir_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;   // cmd, element
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;   // success, count, is_empty

    set_on_linked_array dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // shadow of the node array
    logic [31:0] node_val [CAP];
    logic [6:0]  nxt [CAP];
    logic [6:0]  prv [CAP];
    logic [6:0]  head_i;
    logic [6:0]  tail_i;
    logic [6:0]  free_i;
    int unsigned n_elems;

    set_resp_t resp_q [$];
    pend_t     pend_q [$];
    int        errors;
    bit        no_idle;

    dir_row_t dir_tab [22] = '{
        '{sola_pkg::OP_SEARCH, 32'h0000_0000, 1'b1, 1'b0, 7'd0, 1'b1},
        '{sola_pkg::OP_REMOVE, 32'h0000_0005, 1'b1, 1'b0, 7'd0, 1'b1},
        '{OP_NONE,             32'hFFFF_FFFF, 1'b1, 1'b0, 7'd0, 1'b1},
        '{sola_pkg::OP_ADD,    32'h7FFF_FFFF, 1'b1, 1'b1, 7'd1, 1'b0},
        '{sola_pkg::OP_ADD,    32'h8000_0000, 1'b1, 1'b1, 7'd2, 1'b0},
        '{sola_pkg::OP_ADD,    32'h7FFF_FFFF, 1'b1, 1'b0, 7'd2, 1'b0},
        '{sola_pkg::OP_SEARCH, 32'h8000_0000, 1'b1, 1'b1, 7'd2, 1'b0},
        '{sola_pkg::OP_SEARCH, 32'hFFFF_FFFF, 1'b1, 1'b0, 7'd2, 1'b0},
        '{sola_pkg::OP_ADD,    32'hFFFF_FFFF, 1'b1, 1'b1, 7'd3, 1'b0},
        '{sola_pkg::OP_ADD,    32'h0000_0000, 1'b1, 1'b1, 7'd4, 1'b0},
        '{OP_NONE,             32'h7FFF_FFFF, 1'b1, 1'b0, 7'd4, 1'b0},
        '{sola_pkg::OP_REMOVE, 32'h8000_0000, 1'b1, 1'b1, 7'd3, 1'b0},
        '{sola_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, 1'b1, 7'd2, 1'b0},
        '{sola_pkg::OP_REMOVE, 32'h7FFF_FFFF, 1'b1, 1'b1, 7'd1, 1'b0},
        '{sola_pkg::OP_ADD,    32'h5555_5555, 1'b0, 1'b0, 7'd0, 1'b0},
        '{sola_pkg::OP_ADD,    32'hAAAA_AAAA, 1'b0, 1'b0, 7'd0, 1'b0},
        '{sola_pkg::OP_SEARCH, 32'h5555_5555, 1'b0, 1'b0, 7'd0, 1'b0},
        '{sola_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b0, 7'd0, 1'b0},
        '{sola_pkg::OP_REMOVE, 32'h5555_5555, 1'b0, 1'b0, 7'd0, 1'b0},
        '{sola_pkg::OP_REMOVE, 32'hAAAA_AAAA, 1'b1, 1'b1, 7'd0, 1'b1},
        '{sola_pkg::OP_REMOVE, 32'hAAAA_AAAA, 1'b1, 1'b0, 7'd0, 1'b1},
        '{sola_pkg::OP_ADD,    32'h0000_0001, 1'b0, 1'b0, 7'd0, 1'b0}
    };

    task automatic report(input string field, input int got, input int want);
        errors++;
        $display("%0t: %s mismatch: got %0d, want %0d", $realtime, field, got, want);
    endtask

    function automatic logic [6:0] locate(input logic [31:0] v);
        logic [6:0] cur;
        int         steps;
        cur   = head_i;
        steps = 0;
        // stop at a bad link or after a full lap
        while (cur < CAP && steps < CAP)
        begin
            if (node_val[cur] == v)
                return cur;
            cur = nxt[cur];
            steps++;
        end
        return NIL;
    endfunction

    task automatic set_apply(input logic [sola_pkg::CMD_W-1:0] op, input logic [31:0] v,
                             output set_resp_t r);
        logic [6:0] n;
        logic [6:0] p;
        logic [6:0] q;
        bit         ok;
        ok = 1'b0;
        case (op)
            sola_pkg::OP_SEARCH: ok = (locate(v) != NIL);
            sola_pkg::OP_ADD:
                if (locate(v) == NIL && free_i < CAP)
                begin
                    n         = free_i;
                    free_i    = nxt[n];
                    node_val[n] = v;
                    nxt[n]    = NIL;
                    prv[n]    = tail_i;
                    if (head_i >= CAP)
                        head_i = n;
                    else if (tail_i < CAP)
                        nxt[tail_i] = n;
                    tail_i = n;
                    n_elems++;
                    ok = 1'b1;
                end
            sola_pkg::OP_REMOVE:
            begin
                n = locate(v);
                if (n != NIL)
                begin
                    p = prv[n];
                    q = nxt[n];
                    if (p < CAP) nxt[p] = q;
                    else         head_i = q;
                    if (q < CAP) prv[q] = p;
                    else         tail_i = p;
                    nxt[n]      = free_i;
                    prv[n]      = NIL;
                    node_val[n] = '0;
                    free_i      = n;
                    if (n_elems > 0)
                        n_elems--;
                    ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.success  = ok;
        r.count    = n_elems[6:0];
        r.is_empty = (n_elems == 0);
    endtask

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        for (int i = 0; i < CAP; i++)
        begin
            node_val[i] = '0;
            nxt[i]      = (i + 1 < CAP) ? 7'(i + 1) : NIL;
            prv[i]      = (i == 0) ? NIL : 7'(i - 1);
        end
        head_i  = NIL;
        tail_i  = NIL;
        free_i  = '0;
        n_elems = 0;
        errors  = 0;
        no_idle = 1'b0;
    end

    // accepted input word: predict and queue the expected result
    always @(posedge clk)
    begin : in_mon
        pend_t     pd;
        set_resp_t r;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            if (pend_q.size() == 0)
                report("input bookkeeping", 0, 1);
            else
            begin
                pd = pend_q.pop_front();
                set_apply(s_axis_tdata[1:0], s_axis_tdata[33:2], r);
                if (pd.typed)
                    r = pd.resp;
                resp_q.push_back(r);
            end
        end
    end

    always @(posedge clk)
    begin : out_mon
        set_resp_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (resp_q.size() == 0)
                report("unexpected result word", 1, 0);
            else
            begin
                e = resp_q.pop_front();
                if (m_axis_tdata[0] !== e.success)
                    report("success", int'(m_axis_tdata[0]), int'(e.success));
                if (m_axis_tdata[7:1] !== e.count)
                    report("count", int'(m_axis_tdata[7:1]), int'(e.count));
                if (m_axis_tdata[8] !== e.is_empty)
                    report("is_empty", int'(m_axis_tdata[8]), int'(e.is_empty));
            end
        end
    end

    always @(posedge clk)
    begin : wdog
        int quiet;
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WDOG_MAX)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // result side: random stalls, one long hold to back up the block
    initial
    begin : rx_proc
        int gap;
        int taken;
        m_axis_tready = 1'b0;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(6);
            if (taken == 500)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            else if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            taken++;
        end
    end

    task automatic send_word(input logic [sola_pkg::CMD_W-1:0] op, input logic [31:0] v,
                             input bit typed, input set_resp_t r);
        int    gap;
        pend_t pd;
        gap = no_idle ? 0 : $urandom_range(6);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pd.typed = typed;
        pd.resp  = r;
        pend_q.push_back(pd);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, v, op};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        while (pend_q.size() != 0 || resp_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : tx_proc
        int                         add_pct [N_PHASES];
        int                         pool_sz [N_PHASES];
        logic [31:0]                pool [128];
        set_resp_t                  r;
        logic [sola_pkg::CMD_W-1:0] op;
        logic [31:0]                v;
        int                         pick;
        add_pct = '{90, 50, 15, 90, 50, 20, 95, 10};
        pool_sz = '{96, 16, 96, 80, 8, 96, 100, 100};
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        @(posedge rst_n);
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            r.success  = dir_tab[i].ok;
            r.count    = dir_tab[i].cnt;
            r.is_empty = dir_tab[i].emp;
            send_word(dir_tab[i].op, dir_tab[i].elem, dir_tab[i].typed, r);
        end

        r = '{1'b0, 7'd0, 1'b0};
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            // pause until the block has returned everything
            if (ph == 4)
                drain_all();
            no_idle = (ph == 3);
            foreach (pool[i])
                pool[i] = ($urandom_range(3) == 0) ? 32'($signed($urandom_range(31)) - 16)
                                                   : $urandom;
            for (int k = 0; k < PHASE_LEN; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 3)
                    op = OP_NONE;
                else if (pick < 20)
                    op = sola_pkg::OP_SEARCH;
                else if ($urandom_range(99) < add_pct[ph])
                    op = sola_pkg::OP_ADD;
                else
                    op = sola_pkg::OP_REMOVE;
                v = ($urandom_range(9) == 0) ? $urandom : pool[$urandom_range(pool_sz[ph] - 1)];
                send_word(op, v, 1'b0, r);
            end
        end

        drain_all();
        no_idle = 1'b0;
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
